/* rtl/cavf_pkg.sv */
package cavf_pkg;

	// Fixed formats of the sample and result words
	localparam int ACC_W   = 16;
	localparam int RATE_W  = 32;
	localparam int DT_W    = 24;
	localparam int ANG_W   = 32;
	localparam int WGT_W   = 17;
	localparam int TAB_FRAC = 24;
	localparam int CORD_W  = 50;
	localparam int Z_W     = 34;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = 57;

	localparam logic [WGT_W-1:0] WGT_ONE   = 17'd65536;
	localparam logic [WGT_W-1:0] WGT_RESET = 17'd64225;

	// Sample word as it sits in the queue, with front-end classification
	typedef struct packed {
		logic signed [ACC_W-1:0]  accel_x;
		logic signed [ACC_W-1:0]  accel_y;
		logic signed [ACC_W-1:0]  accel_z;
		logic signed [RATE_W-1:0] rate_roll;
		logic signed [RATE_W-1:0] rate_pitch;
		logic [DT_W-1:0]          step_time;
		logic [31:0]              sumsq;
		logic                     roll_zero;
		logic                     pitch_zero;
	} cavf_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CROLL,
		ST_CPITCH,
		ST_MRATE,
		ST_GYRO,
		ST_MGW,
		ST_MAW,
		ST_BLEND,
		ST_EMIT
	} cavf_state_t;

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			5'd0:  r = 34'sd754974720;
			5'd1:  r = 34'sd445687602;
			5'd2:  r = 34'sd235489088;
			5'd3:  r = 34'sd119537938;
			5'd4:  r = 34'sd60000934;
			5'd5:  r = 34'sd30029717;
			5'd6:  r = 34'sd15018523;
			5'd7:  r = 34'sd7509720;
			5'd8:  r = 34'sd3754917;
			5'd9:  r = 34'sd1877466;
			5'd10: r = 34'sd938734;
			5'd11: r = 34'sd469367;
			5'd12: r = 34'sd234683;
			5'd13: r = 34'sd117342;
			5'd14: r = 34'sd58671;
			5'd15: r = 34'sd29335;
			5'd16: r = 34'sd14668;
			5'd17: r = 34'sd7334;
			5'd18: r = 34'sd3667;
			5'd19: r = 34'sd1833;
			5'd20: r = 34'sd917;
			5'd21: r = 34'sd458;
			5'd22: r = 34'sd229;
			5'd23: r = 34'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp to the 32-bit signed range
	function automatic logic signed [ANG_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [ANG_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[ANG_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/cavf_if.sv */
interface cavf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [31:0] rate_roll;
	logic signed [31:0] rate_pitch;
	logic [23:0]        step_time;

	modport source (output valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch,
		step_time, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, rate_roll, rate_pitch,
		step_time, output ready);
endinterface

interface cavf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] roll_out;
	logic signed [31:0] pitch_out;

	modport source (output valid, roll_out, pitch_out, input ready);
	modport sink (input valid, roll_out, pitch_out, output ready);
endinterface

interface cavf_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/cavf_front.sv */
module cavf_front (
	cavf_in_if.sink                sample,
	input  logic                   full,
	output logic                   push,
	output cavf_pkg::cavf_item_t   item
);
	import cavf_pkg::*;

	logic signed [31:0] ysq;
	logic signed [31:0] zsq;

	// Accept while the queue has room
	assign sample.ready = !full;
	assign push = sample.valid && !full;

	// Square the horizontal components for the pitch magnitude
	assign ysq = 32'(sample.accel_y * sample.accel_y);
	assign zsq = 32'(sample.accel_z * sample.accel_z);

	// Pack the word and flag the degenerate atan2 cases
	always_comb begin
		item.accel_x    = sample.accel_x;
		item.accel_y    = sample.accel_y;
		item.accel_z    = sample.accel_z;
		item.rate_roll  = sample.rate_roll;
		item.rate_pitch = sample.rate_pitch;
		item.step_time  = sample.step_time;
		item.sumsq      = unsigned'(ysq) + unsigned'(zsq);
		item.roll_zero  = (sample.accel_y == '0) && (sample.accel_z == '0);
		item.pitch_zero = item.roll_zero && (sample.accel_x == '0);
	end

endmodule

/* rtl/cavf_queue.sv */
module cavf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cavf_pkg::cavf_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output cavf_pkg::cavf_item_t pop_item
);
	import cavf_pkg::*;

	cavf_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_item  = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2) else $error("push into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("occupancy did not grow");

endmodule

/* rtl/cavf_back.sv */
module cavf_back #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cavf_pkg::cavf_item_t q_item,
	output logic                 pop,
	cavf_cfg_if.sink             cfg,
	cavf_out_if.source           result
);
	import cavf_pkg::*;

	localparam int SH = TAB_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [39:0] OFS_IN  = 40'sd360 <<< TAB_FRAC;
	localparam logic signed [39:0] OFS_OUT = 40'sd360 <<< ANGLE_FRAC_BITS;
	localparam logic signed [39:0] HALF    = (40'sd1 <<< SH) >>> 1;
	localparam logic [5:0] SQRT_STEPS = 6'd32;
	localparam logic [5:0] CSTEPS     = 6'(CORDIC_STEPS);

	cavf_state_t state_q, state_d;
	cavf_item_t  item_q;
	logic [WGT_W-1:0] w_q;
	logic [5:0]  cnt_q;
	logic [63:0] n_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic signed [CORD_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic        zero_q;
	logic signed [ANG_W-1:0]  acc_roll_q, acc_pitch_q;
	logic signed [ANG_W-1:0]  roll_q, pitch_q;
	logic signed [ANG_W-1:0]  g_q;
	logic signed [PROD_W-1:0] prod_q;
	logic        axis_q;
	logic        res_valid_q;
	logic signed [ANG_W-1:0]  roll_out_q, pitch_out_q;

	logic        emit_go;
	logic [34:0] remn, trial;
	logic signed [CORD_W-1:0] cx, cy, x0, y0, dx, dy;
	logic signed [Z_W-1:0]    z0;
	logic        zero0;
	logic signed [39:0] zt, zs;
	logic signed [ANG_W-1:0]  conv;
	logic [WGT_W-1:0] wc;
	logic signed [MUL_A_W-1:0] ma;
	logic signed [MUL_B_W-1:0] mb;
	logic signed [PROD_W-1:0]  mp;
	logic signed [ANG_W-1:0]  rate_sel, angle_sel, acc_sel;
	logic signed [33:0] gsum;
	logic signed [PROD_W-1:0] bsum;
	logic signed [ANG_W-1:0]  blended;

	// Configuration register, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WGT_RESET;
		end else if (cfg.valid) begin
			w_q <= cfg.data;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (q_valid) state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == SQRT_STEPS) state_d = ST_CROLL;
			ST_CROLL:  if (cnt_q == CSTEPS) state_d = ST_CPITCH;
			ST_CPITCH: if (cnt_q == CSTEPS) state_d = ST_MRATE;
			ST_MRATE:  state_d = ST_GYRO;
			ST_GYRO:   state_d = ST_MGW;
			ST_MGW:    state_d = ST_MAW;
			ST_MAW:    state_d = ST_BLEND;
			ST_BLEND:  state_d = axis_q ? ST_EMIT : ST_MRATE;
			ST_EMIT:   if (emit_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop     = (state_q == ST_IDLE) && q_valid;
		emit_go = (state_q == ST_EMIT) && (!res_valid_q || result.ready);
	end

	// One digit of the square root
	assign remn  = {rem_q[32:0], n_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	// CORDIC operands: roll while leaving the root, pitch while leaving roll
	always_comb begin
		if (state_q == ST_SQRT) begin
			cy = {{18{item_q.accel_y[15]}}, item_q.accel_y, 16'b0};
			cx = {{18{item_q.accel_z[15]}}, item_q.accel_z, 16'b0};
			zero0 = item_q.roll_zero;
		end else begin
			cy = -{{18{item_q.accel_x[15]}}, item_q.accel_x, 16'b0};
			cx = {18'b0, root_q};
			zero0 = item_q.pitch_zero;
		end
		if (cx[CORD_W-1]) begin
			x0 = -cx;
			y0 = -cy;
			z0 = cy[CORD_W-1] ? -(34'sd180 <<< TAB_FRAC) : (34'sd180 <<< TAB_FRAC);
		end else begin
			x0 = cx;
			y0 = cy;
			z0 = '0;
		end
	end

	// CORDIC micro-rotation terms
	assign dx = y_q >>> cnt_q[4:0];
	assign dy = x_q >>> cnt_q[4:0];

	// Round the accumulated angle to the output format
	always_comb begin
		zt   = (zero_q ? 40'sd0 : 40'(z_q)) + OFS_IN + HALF;
		zs   = zt >>> SH;
		conv = sat32(64'(zs - OFS_OUT));
	end

	// Shared multiplier
	assign wc = (w_q > WGT_ONE) ? WGT_ONE : w_q;
	always_comb begin
		rate_sel  = axis_q ? item_q.rate_pitch : item_q.rate_roll;
		angle_sel = axis_q ? pitch_q : roll_q;
		acc_sel   = axis_q ? acc_pitch_q : acc_roll_q;
		unique case (state_q)
			ST_MRATE: begin
				ma = rate_sel;
				mb = {1'b0, item_q.step_time};
			end
			ST_MGW: begin
				ma = g_q;
				mb = 25'(wc);
			end
			default: begin
				ma = acc_sel;
				mb = 25'(WGT_ONE - wc);
			end
		endcase
		mp      = PROD_W'(ma * mb);
		gsum    = 34'(angle_sel) + 34'((prod_q + 57'sd8388608) >>> 24);
		bsum    = (prod_q + 57'sd32768) >>> 16;
		blended = sat32(64'(bsum));
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				n_q    <= {q_item.sumsq, 32'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				if (cnt_q == SQRT_STEPS) begin
					x_q    <= x0;
					y_q    <= y0;
					z_q    <= z0;
					zero_q <= zero0;
				end else begin
					n_q <= {n_q[61:0], 2'b0};
					if (remn >= trial) begin
						rem_q  <= remn - trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= remn;
						root_q <= {root_q[30:0], 1'b0};
					end
				end
			end
			ST_CROLL, ST_CPITCH: begin
				if (cnt_q == CSTEPS) begin
					if (state_q == ST_CROLL) begin
						acc_roll_q <= conv;
						x_q    <= x0;
						y_q    <= y0;
						z_q    <= z0;
						zero_q <= zero0;
					end else begin
						acc_pitch_q <= conv;
					end
				end else if (!y_q[CORD_W-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_deg(cnt_q[4:0]);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_deg(cnt_q[4:0]);
				end
			end
			ST_MRATE: prod_q <= mp;
			ST_GYRO:  g_q <= sat32(64'(gsum));
			ST_MGW:   prod_q <= mp;
			ST_MAW:   prod_q <= prod_q + mp;
			default: begin
			end
		endcase
	end

	// Control registers: state, counters, angles and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQRT || state_q == ST_CROLL
					|| state_q == ST_CPITCH) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (state_q == ST_CPITCH) axis_q <= 1'b0;
			if (state_q == ST_BLEND) begin
				axis_q <= 1'b1;
				if (axis_q) pitch_q <= blended;
				else roll_q <= blended;
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (emit_go) begin
			roll_out_q  <= roll_q;
			pitch_out_q <= pitch_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.roll_out  = roll_out_q;
	assign result.pitch_out = pitch_out_q;

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> res_valid_q) else $error("result word lost");
	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> cnt_q <= SQRT_STEPS) else $error("root counter overrun");
	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CROLL || state_q == ST_CPITCH) |-> cnt_q <= CSTEPS)
		else $error("rotation counter overrun");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_SQRT) else $error("pop outside idle");

endmodule

/* rtl/complementary_attitude_filter_core.sv */
// Each sample word becomes a result word in a shared square-root / CORDIC / multiplier sequencer,
// which finishes one word before it takes the next from the queue; a two-word queue and the output
// register decouple the ports.
// Reset (arst_n low, asynchronous): angles clear to zero, gyro_weight returns to 64225,
// queue and result register empty.
module complementary_attitude_filter_core #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	cavf_in_if.sink    sample,
	cavf_cfg_if.sink   cfg,
	cavf_out_if.source result
);
	import cavf_pkg::*;

	logic       push, full, pop, q_valid;
	cavf_item_t push_item, q_item;

	// Accept and classify
	cavf_front u_front (
		.sample (sample),
		.full   (full),
		.push   (push),
		.item   (push_item)
	);

	// Decouple front and back
	cavf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// Compute angles and blend
	cavf_back #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.cfg     (cfg),
		.result  (result)
	);

endmodule
